// ===== rtl/fhv_pkg.sv =====
// ----------------------------------------------------------------------------
// fhv_pkg
// Types and constants shared by the frame header validator modules.
// ----------------------------------------------------------------------------
package fhv_pkg;

    localparam int HDR_SIZE  = 64;
    localparam int OFFSET_W  = 64;
    localparam int CHUNK_W   = 32;
    localparam int VERDICT_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CELLS = OFFSET_W;
    localparam int LATENCY   = NUM_CELLS + 2;

    localparam logic [CHUNK_W-1:0] HDR_BYTES   = CHUNK_W'(HDR_SIZE);
    localparam logic [15:0]        HDR_LEN_VAL = 16'(HDR_SIZE);

    localparam logic [VERDICT_W-1:0] V_OK        = 4'd0;
    localparam logic [VERDICT_W-1:0] V_SHORT     = 4'd1;
    localparam logic [VERDICT_W-1:0] V_MAGIC     = 4'd2;
    localparam logic [VERDICT_W-1:0] V_VERSION   = 4'd3;
    localparam logic [VERDICT_W-1:0] V_HDRLEN    = 4'd4;
    localparam logic [VERDICT_W-1:0] V_RESERVED  = 4'd5;
    localparam logic [VERDICT_W-1:0] V_CLUSTER   = 4'd6;
    localparam logic [VERDICT_W-1:0] V_SCHEMA    = 4'd7;
    localparam logic [VERDICT_W-1:0] V_LENGTH    = 4'd8;
    localparam logic [VERDICT_W-1:0] V_PLACEMENT = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEMA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK   = 3'd4;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 32'd4096;

    typedef struct packed {
        logic [31:0]        magic;
        logic [15:0]        version;
        logic [31:0]        cluster;
        logic [31:0]        schema;
        logic [CHUNK_W-1:0] chunk;
    } cfg_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] pre;
        logic [CHUNK_W-1:0]   rem;
        logic [OFFSET_W-1:0]  dividend;
    } stage_t;

endpackage

// ===== rtl/frame_header_validator.sv =====
// ----------------------------------------------------------------------------
// frame_header_validator
// Classifies one cluster frame header per cycle and reports a verdict.
//
//   channel   signals                               handshake
//   -------   -----------------------------------   ----------------------
//   header    start, busy, header fields            start && !busy
//   config    cfg_valid, cfg_ready, cfg_index/data  cfg_valid && cfg_ready
//   result    done, verdict, accepted               done, one cycle
//
// A new header is taken every cycle; busy stays low.
// Each transaction passes one check stage, 64 remainder cells for the ring
// offset and one output register before its result appears.
// Reset clears the chain valid bits and restores the register defaults.
// The result side cannot stall, so nothing backs up in the chain.
// ----------------------------------------------------------------------------
module frame_header_validator
    import fhv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          frame_bytes,
    input  logic [31:0]          magic_word,
    input  logic [15:0]          version_field,
    input  logic [15:0]          header_length,
    input  logic [31:0]          cluster_tag,
    input  logic [31:0]          schema_tag,
    input  logic [31:0]          payload_bytes,
    input  logic [63:0]          ring_offset,
    input  logic [63:0]          reserved_low,
    input  logic [63:0]          reserved_high,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output logic [VERDICT_W-1:0] verdict,
    output logic                 accepted
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 take;
    logic                 chain_valid [0:NUM_CELLS];
    stage_t               chain_stage [0:NUM_CELLS];
    stage_t               last_stage;
    logic                 done_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [VERDICT_W-1:0] verdict_next;
    logic                 accepted_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAGIC:   cfg_next.magic   = cfg_data;
                CFG_VERSION: cfg_next.version = cfg_data[15:0];
                CFG_CLUSTER: cfg_next.cluster = cfg_data;
                CFG_SCHEMA:  cfg_next.schema  = cfg_data;
                CFG_CHUNK:   cfg_next.chunk   = (cfg_data < HDR_BYTES) ? HDR_BYTES : cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic   <= '0;
            cfg_reg.version <= '0;
            cfg_reg.cluster <= '0;
            cfg_reg.schema  <= '0;
            cfg_reg.chunk   <= CHUNK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fhv_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .cfg           (cfg_reg),
        .frame_bytes   (frame_bytes),
        .magic_word    (magic_word),
        .version_field (version_field),
        .header_length (header_length),
        .cluster_tag   (cluster_tag),
        .schema_tag    (schema_tag),
        .payload_bytes (payload_bytes),
        .ring_offset   (ring_offset),
        .reserved_low  (reserved_low),
        .reserved_high (reserved_high),
        .out_valid     (chain_valid[0]),
        .out_stage     (chain_stage[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        fhv_mod_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .chunk     (cfg_reg.chunk),
            .in_valid  (chain_valid[i]),
            .in_stage  (chain_stage[i]),
            .out_valid (chain_valid[i+1]),
            .out_stage (chain_stage[i+1])
        );
    end

    assign last_stage = chain_stage[NUM_CELLS];

    always_comb
    begin
        if (last_stage.pre != V_OK)
        begin
            verdict_next = last_stage.pre;
        end
        else if (last_stage.rem != '0)
        begin
            verdict_next = V_PLACEMENT;
        end
        else
        begin
            verdict_next = V_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg  <= verdict_next;
        accepted_reg <= (verdict_next == V_OK);
    end

    assign done     = done_reg;
    assign verdict  = verdict_reg;
    assign accepted = accepted_reg;

`ifndef SYNTH
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##LATENCY done)
        else $error("header transaction produced no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, LATENCY))
        else $error("result without a header transaction");

    a_accept_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (accepted == (verdict == V_OK)))
        else $error("accepted flag disagrees with verdict");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (verdict <= V_PLACEMENT))
        else $error("verdict code out of range");
`endif

endmodule

// ===== rtl/fhv_check.sv =====
// ----------------------------------------------------------------------------
// fhv_check
// Entry stage: runs the ordered field checks and loads the remainder chain.
// ----------------------------------------------------------------------------
module fhv_check
    import fhv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  cfg_t                cfg,
    input  logic [31:0]         frame_bytes,
    input  logic [31:0]         magic_word,
    input  logic [15:0]         version_field,
    input  logic [15:0]         header_length,
    input  logic [31:0]         cluster_tag,
    input  logic [31:0]         schema_tag,
    input  logic [31:0]         payload_bytes,
    input  logic [OFFSET_W-1:0] ring_offset,
    input  logic [63:0]         reserved_low,
    input  logic [63:0]         reserved_high,
    output logic                out_valid,
    output stage_t              out_stage
);

    logic                 valid_reg;
    stage_t               stage_reg;
    stage_t               stage_next;
    logic [VERDICT_W-1:0] pre;
    logic [CHUNK_W-1:0]   fit_limit;

    assign fit_limit = cfg.chunk - HDR_BYTES;

    always_comb
    begin
        if (frame_bytes < HDR_BYTES)
        begin
            pre = V_SHORT;
        end
        else if (magic_word != cfg.magic)
        begin
            pre = V_MAGIC;
        end
        else if (version_field != cfg.version)
        begin
            pre = V_VERSION;
        end
        else if (header_length != HDR_LEN_VAL)
        begin
            pre = V_HDRLEN;
        end
        else if ((reserved_low != 64'd0) || (reserved_high != 64'd0))
        begin
            pre = V_RESERVED;
        end
        else if ((cfg.cluster != 32'd0) && (cluster_tag != cfg.cluster))
        begin
            pre = V_CLUSTER;
        end
        else if ((cfg.schema != 32'd0) && (schema_tag != cfg.schema))
        begin
            pre = V_SCHEMA;
        end
        else if (payload_bytes > fit_limit)
        begin
            pre = V_LENGTH;
        end
        else
        begin
            pre = V_OK;
        end
    end

    always_comb
    begin
        stage_next.pre      = pre;
        stage_next.rem      = '0;
        stage_next.dividend = ring_offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/fhv_mod_cell.sv =====
// ----------------------------------------------------------------------------
// fhv_mod_cell
// One restoring step of the ring offset remainder: brings in one dividend bit.
// ----------------------------------------------------------------------------
module fhv_mod_cell
    import fhv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CHUNK_W-1:0] chunk,
    input  logic               in_valid,
    input  stage_t             in_stage,
    output logic               out_valid,
    output stage_t             out_stage
);

    logic               valid_reg;
    stage_t             stage_reg;
    stage_t             stage_next;
    logic [CHUNK_W:0]   shifted;
    logic [CHUNK_W:0]   diff;

    assign shifted = {in_stage.rem, in_stage.dividend[OFFSET_W-1]};
    assign diff    = shifted - {1'b0, chunk};

    always_comb
    begin
        stage_next.pre      = in_stage.pre;
        stage_next.dividend = {in_stage.dividend[OFFSET_W-2:0], 1'b0};
        if (shifted >= {1'b0, chunk})
        begin
            stage_next.rem = diff[CHUNK_W-1:0];
        end
        else
        begin
            stage_next.rem = shifted[CHUNK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== bench/frame_header_validator_test.sv =====
// ----------------------------------------------------------------------------
// frame_header_validator_test
// Self-checking bench for the cluster frame header validator. A driver feeds
// header transactions from a backlog with random gaps, a predictor computes
// the expected verdict for each accepted header, and a monitor compares every
// result strobe against the oldest prediction. Register settings change
// between phases while the block is idle, covering the extreme values.
// ----------------------------------------------------------------------------
module frame_header_validator_test
    import fhv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] frame_bytes;
        logic [31:0] magic_word;
        logic [15:0] version_field;
        logic [15:0] header_length;
        logic [31:0] cluster_tag;
        logic [31:0] schema_tag;
        logic [31:0] payload_bytes;
        logic [63:0] ring_offset;
        logic [63:0] reserved_low;
        logic [63:0] reserved_high;
    } header_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic                 accepted;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [31:0]          frame_bytes = '0;
    logic [31:0]          magic_word = '0;
    logic [15:0]          version_field = '0;
    logic [15:0]          header_length = '0;
    logic [31:0]          cluster_tag = '0;
    logic [31:0]          schema_tag = '0;
    logic [31:0]          payload_bytes = '0;
    logic [63:0]          ring_offset = '0;
    logic [63:0]          reserved_low = '0;
    logic [63:0]          reserved_high = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 done;
    logic [VERDICT_W-1:0] verdict;
    logic                 accepted;

    // Shadow copy of the register file.
    logic [31:0] want_magic;
    logic [15:0] want_version;
    logic [31:0] want_cluster;
    logic [31:0] want_schema;
    logic [31:0] want_chunk;

    header_t  header_backlog[$];
    outcome_t pending_verdicts[$];
    header_t  cur_header;
    int       gap_left = 0;
    bit       burst_mode = 1'b0;
    int       headers_sent = 0;
    int       verdicts_checked = 0;
    int       frames_accepted = 0;
    int       mismatches = 0;
    int       settings_used = 0;

    frame_header_validator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .frame_bytes   (frame_bytes),
        .magic_word    (magic_word),
        .version_field (version_field),
        .header_length (header_length),
        .cluster_tag   (cluster_tag),
        .schema_tag    (schema_tag),
        .payload_bytes (payload_bytes),
        .ring_offset   (ring_offset),
        .reserved_low  (reserved_low),
        .reserved_high (reserved_high),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .verdict       (verdict),
        .accepted      (accepted)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [VERDICT_W-1:0] classify_header(header_t h);
        if (h.frame_bytes < HDR_BYTES)
            return V_SHORT;
        if (h.magic_word != want_magic)
            return V_MAGIC;
        if (h.version_field != want_version)
            return V_VERSION;
        if (h.header_length != HDR_LEN_VAL)
            return V_HDRLEN;
        if (h.reserved_low != '0 || h.reserved_high != '0)
            return V_RESERVED;
        if (want_cluster != '0 && h.cluster_tag != want_cluster)
            return V_CLUSTER;
        if (want_schema != '0 && h.schema_tag != want_schema)
            return V_SCHEMA;
        if (h.payload_bytes > want_chunk - HDR_BYTES)
            return V_LENGTH;
        if (h.ring_offset % {32'd0, want_chunk} != '0)
            return V_PLACEMENT;
        return V_OK;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A header that passes every check under the current register settings.
    function automatic header_t good_header();
        header_t h;
        case ($urandom_range(0, 9))
            0: h.frame_bytes = HDR_BYTES;
            1: h.frame_bytes = 32'hFFFF_FFFF;
            default: h.frame_bytes = $urandom_range(HDR_SIZE, 32'hFFFF_FFFF);
        endcase
        h.magic_word    = want_magic;
        h.version_field = want_version;
        h.header_length = HDR_LEN_VAL;
        h.cluster_tag   = (want_cluster != '0) ? want_cluster : $urandom;
        h.schema_tag    = (want_schema != '0) ? want_schema : $urandom;
        case ($urandom_range(0, 5))
            0: h.payload_bytes = '0;
            1: h.payload_bytes = want_chunk - HDR_BYTES;
            default: h.payload_bytes = $urandom_range(0, want_chunk - HDR_BYTES);
        endcase
        case ($urandom_range(0, 5))
            0: h.ring_offset = '0;
            1: h.ring_offset = 64'(want_chunk) * 64'h0000_0000_FFFF_FFFF;
            2: h.ring_offset = 64'($urandom_range(0, 100)) * 64'(want_chunk);
            default: h.ring_offset = 64'($urandom) * 64'(want_chunk);
        endcase
        h.reserved_low  = '0;
        h.reserved_high = '0;
        return h;
    endfunction

    function automatic header_t break_header(header_t h, logic [VERDICT_W-1:0] fault);
        case (fault)
            V_SHORT:
                h.frame_bytes = $urandom_range(0, HDR_SIZE - 1);
            V_MAGIC:
                h.magic_word = h.magic_word ^ ($urandom_range(0, 1) ?
                    (32'd1 << $urandom_range(0, 31)) : $urandom);
            V_VERSION:
                h.version_field = h.version_field ^ ($urandom_range(0, 1) ?
                    (16'd1 << $urandom_range(0, 15)) : 16'($urandom));
            V_HDRLEN:
                h.header_length = $urandom_range(0, 1) ?
                    (HDR_LEN_VAL ^ (16'd1 << $urandom_range(0, 15))) : 16'($urandom);
            V_RESERVED:
                case ($urandom_range(0, 2))
                    0: h.reserved_low = 64'd1 << $urandom_range(0, 63);
                    1: h.reserved_high = 64'd1 << $urandom_range(0, 63);
                    default:
                    begin
                        h.reserved_low  = {$urandom, $urandom};
                        h.reserved_high = {$urandom, $urandom};
                    end
                endcase
            V_CLUSTER:
                h.cluster_tag = (want_cluster != '0) ?
                    (want_cluster ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
            V_SCHEMA:
                h.schema_tag = (want_schema != '0) ?
                    (want_schema ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
            V_LENGTH:
                h.payload_bytes = $urandom_range(want_chunk - HDR_BYTES + 1, 32'hFFFF_FFFF);
            V_PLACEMENT:
                h.ring_offset = h.ring_offset + 64'($urandom_range(1, want_chunk - 1));
            default: ;
        endcase
        return h;
    endfunction

    function automatic header_t noise_header();
        header_t h;
        h.frame_bytes   = $urandom;
        h.magic_word    = $urandom;
        h.version_field = 16'($urandom);
        h.header_length = 16'($urandom);
        h.cluster_tag   = $urandom;
        h.schema_tag    = $urandom;
        h.payload_bytes = $urandom;
        h.ring_offset   = {$urandom, $urandom};
        h.reserved_low  = {$urandom, $urandom};
        h.reserved_high = {$urandom, $urandom};
        return h;
    endfunction

    function automatic header_t random_header();
        header_t h;
        int      r;
        int      faults;
        r = $urandom_range(0, 99);
        if (r >= 90)
            return noise_header();
        h = good_header();
        if (r >= 45)
        begin
            faults = $urandom_range(1, 3);
            repeat (faults)
                h = break_header(h, VERDICT_W'($urandom_range(V_SHORT, V_PLACEMENT)));
        end
        return h;
    endfunction

    // Register shadow follows every configuration transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            want_magic   <= '0;
            want_version <= '0;
            want_cluster <= '0;
            want_schema  <= '0;
            want_chunk   <= CHUNK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAGIC:   want_magic <= cfg_data;
                CFG_VERSION: want_version <= cfg_data[15:0];
                CFG_CLUSTER: want_cluster <= cfg_data;
                CFG_SCHEMA:  want_schema <= cfg_data;
                CFG_CHUNK:   want_chunk <= (cfg_data < HDR_BYTES) ? HDR_BYTES : cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : header_driver
        logic [VERDICT_W-1:0] v;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                v = classify_header(cur_header);
                pending_verdicts.push_back('{verdict: v, accepted: (v == V_OK)});
                headers_sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (header_backlog.size() != 0)
                begin
                    cur_header = header_backlog.pop_front();
                    frame_bytes   <= cur_header.frame_bytes;
                    magic_word    <= cur_header.magic_word;
                    version_field <= cur_header.version_field;
                    header_length <= cur_header.header_length;
                    cluster_tag   <= cur_header.cluster_tag;
                    schema_tag    <= cur_header.schema_tag;
                    payload_bytes <= cur_header.payload_bytes;
                    ring_offset   <= cur_header.ring_offset;
                    reserved_low  <= cur_header.reserved_low;
                    reserved_high <= cur_header.reserved_high;
                    start <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : verdict_monitor
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 20)
                    $display("%0t: result with no header outstanding, verdict %0d accepted %0b",
                             $time, verdict, accepted);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (want.accepted)
                    frames_accepted++;
                if (verdict !== want.verdict)
                begin
                    mismatches++;
                    if (mismatches <= 20)
                        $display("%0t: verdict expected %0d, actual %0d",
                                 $time, want.verdict, verdict);
                end
                if (accepted !== want.accepted)
                begin
                    mismatches++;
                    if (mismatches <= 20)
                        $display("%0t: accepted expected %0b, actual %0b",
                                 $time, want.accepted, accepted);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(logic [31:0] magic, logic [15:0] version,
                                  logic [31:0] cluster, logic [31:0] schema,
                                  logic [31:0] chunk);
        logic [CFG_IDX_W-1:0] spare_idx;
        spare_idx = CFG_CHUNK + CFG_IDX_W'($urandom_range(1, 3));
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {16'($urandom), version});
        write_reg(CFG_CLUSTER, cluster);
        write_reg(CFG_SCHEMA, schema);
        write_reg(CFG_CHUNK, chunk);
        // Writes past the last register must leave everything unchanged.
        write_reg(spare_idx, $urandom);
        @(negedge clk);
        settings_used++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (header_backlog.size() != 0 || start || pending_verdicts.size() != 0);
    endtask

    task automatic queue_header(header_t h);
        header_backlog.push_back(h);
    endtask

    initial
    begin : stimulus
        header_t     h;
        logic [31:0] magic;
        logic [15:0] version;
        logic [31:0] cluster;
        logic [31:0] schema;
        logic [31:0] chunk;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed headers against the reset register values.
        h = good_header();
        queue_header(h);
        h.frame_bytes = '0;            queue_header(h);
        h.frame_bytes = HDR_BYTES - 1; queue_header(h);
        h.frame_bytes = HDR_BYTES;     queue_header(h);
        h.frame_bytes = 32'hFFFF_FFFF; queue_header(h);
        h = good_header(); h.magic_word = 32'hFFFF_FFFF;   queue_header(h);
        h = good_header(); h.version_field = 16'hFFFF;     queue_header(h);
        h = good_header(); h.header_length = '0;           queue_header(h);
        h = good_header(); h.header_length = 16'hFFFF;     queue_header(h);
        h = good_header(); h.reserved_low = 64'd1 << 63;   queue_header(h);
        h = good_header(); h.reserved_high = 64'd1;        queue_header(h);
        h = good_header(); h.payload_bytes = want_chunk - HDR_BYTES;     queue_header(h);
        h = good_header(); h.payload_bytes = want_chunk - HDR_BYTES + 1; queue_header(h);
        h = good_header(); h.ring_offset = 64'(want_chunk / 2);          queue_header(h);
        h = good_header(); h.ring_offset = 64'hFFFF_FFFF_FFFF_FFFF;      queue_header(h);
        h = good_header(); h.frame_bytes = 32'd10; h.magic_word = 32'h1; queue_header(h);
        h = good_header(); h.magic_word = 32'h1; h.version_field = 16'h1; queue_header(h);
        wait_drained();

        // Filters on, chunk size written below the minimum.
        apply_settings(32'hA5C3_0F96, 16'h0102, 32'h1234_5678, 32'h9ABC_DEF0, 32'd0);
        h = good_header();                                    queue_header(h);
        h.cluster_tag = want_cluster ^ 32'd1;                 queue_header(h);
        h = good_header(); h.schema_tag = '0;                 queue_header(h);
        h = good_header(); h.payload_bytes = '0; h.ring_offset = 64'd64; queue_header(h);
        h = good_header(); h.payload_bytes = 32'd1;           queue_header(h);
        h = good_header(); h.ring_offset = 64'd32;            queue_header(h);
        h = good_header(); h.payload_bytes = 32'd1; h.ring_offset = 64'd1; queue_header(h);
        wait_drained();

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:
                begin
                    magic = '0; version = '0; cluster = '0; schema = '0; chunk = HDR_BYTES;
                end
                1:
                begin
                    magic = 32'hFFFF_FFFF; version = 16'hFFFF;
                    cluster = 32'hFFFF_FFFF; schema = 32'hFFFF_FFFF; chunk = 32'hFFFF_FFFF;
                end
                2:
                begin
                    magic = $urandom; version = 16'($urandom);
                    cluster = $urandom; schema = '0; chunk = CHUNK_RESET;
                end
                3:
                begin
                    magic = $urandom; version = 16'($urandom);
                    cluster = '0; schema = $urandom; chunk = HDR_BYTES - 1;
                end
                default:
                begin
                    magic = $urandom;
                    version = 16'($urandom);
                    cluster = $urandom_range(0, 1) ? $urandom : '0;
                    schema = $urandom_range(0, 1) ? $urandom : '0;
                    case ($urandom_range(0, 3))
                        0: chunk = 32'd1 << $urandom_range(6, 31);
                        1: chunk = $urandom_range(HDR_SIZE, 100000);
                        2: chunk = $urandom;
                        default: chunk = $urandom_range(0, HDR_SIZE - 1);
                    endcase
                end
            endcase
            apply_settings(magic, version, cluster, schema, chunk);
            burst_mode = (phase % 3 == 2);
            repeat (100)
                queue_header(random_header());
            wait_drained();
        end

        repeat (LATENCY + 4) @(posedge clk);
        $display("Checked %0d verdicts for %0d headers, %0d accepted, over %0d register settings.",
                 verdicts_checked, headers_sent, frames_accepted, settings_used);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Run did not complete in time.");
        $display("== FAIL ==");
        $finish;
    end

endmodule
